@@ hw/rtl/pair_ring_queue_with_delete_macros.svh @@
// Assertion macros for the pair ring queue.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PAIR_RING_QUEUE_WITH_DELETE_MACROS_SVH
`define PAIR_RING_QUEUE_WITH_DELETE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pair ring queue check failed");

// Next-cycle implication, disabled during reset
`define PRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pair ring queue check failed");

`endif

@@ hw/rtl/prq_pkg.sv @@
// Package for the pair ring queue: beat types, request and status codes.
// No dependencies.
package prq_pkg;

  // Request codes
  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_DEQ    = 2'd1;
  localparam logic [1:0] REQ_DEL    = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NOELEM  = 2'd3;

  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] first_value;
    logic signed [WORD_W-1:0] second_value;
    logic [3:0]               slot_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [1:0]               removed_count;
    logic signed [WORD_W-1:0] oldest_word;
    logic signed [WORD_W-1:0] next_word;
  } out_beat_t;

endpackage

@@ hw/rtl/pair_ring_queue_with_delete.sv @@
// Pair ring queue: a reject, an unused code or a delete of the last entry goes from the accepted
// beat straight to the done state; an enqueue writes its two words in turn, a dequeue reads the
// oldest word and then the next one if present, other deletes shift each later entry toward the
// head. The next beat is taken in the cycle after the result register loads; the entry memory does
// one write and one registered read per cycle. Reset (rst_n low, synchronous) empties the queue
// and clears head, count and valids; the entry memory is not cleared.
module pair_ring_queue_with_delete #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  prq_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output prq_pkg::out_beat_t out_beat
);

  `include "pair_ring_queue_with_delete_macros.svh"

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ENQ2 = 6'b000010,
    S_DEQ1 = 6'b000100,
    S_DEQ2 = 6'b001000,
    S_DEL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] s);
    return (s == PTR_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  state_t                      state_r, state_nxt;
  logic [PTR_W-1:0]            head_r, head_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [PTR_W-1:0]            cur_r, cur_nxt;
  logic [CNT_W-1:0]            remain_r, remain_nxt;
  logic [prq_pkg::WORD_W-1:0]  second_r, second_nxt;
  prq_pkg::out_beat_t          res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  prq_pkg::out_beat_t          out_beat_r, out_beat_nxt;

  // Entry memory, one write and one registered read port
  logic [prq_pkg::WORD_W-1:0]  mem [RING_DEPTH];
  logic                        mem_we, mem_re;
  logic [PTR_W-1:0]            mem_waddr, mem_raddr;
  logic [prq_pkg::WORD_W-1:0]  mem_wdata, mem_rdata_r;

  logic [SUM_W-1:0]            tail_sum;
  logic [PTR_W-1:0]            tail;
  logic [PTR_W-1:0]            slot_p;
  logic                        slot_in_range;
  logic [CNT_W-1:0]            slot_off;
  logic [CNT_W-1:0]            shift_cnt;
  logic                        out_free;

  // Tail and delete offset, all wrap-aware
  always_comb begin
    tail_sum      = SUM_W'(head_r) + SUM_W'(count_r);
    tail          = (tail_sum >= SUM_W'(RING_DEPTH)) ? PTR_W'(tail_sum - SUM_W'(RING_DEPTH))
                                                     : PTR_W'(tail_sum);
    slot_p        = PTR_W'(in_beat.slot_index);
    slot_in_range = (32'(in_beat.slot_index) < RING_DEPTH);
    slot_off      = CNT_W'(slot_p) - CNT_W'(head_r)
                  + ((slot_p < head_r) ? CNT_W'(RING_DEPTH) : '0);
    shift_cnt     = count_r - CNT_W'(1) - slot_off;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Sequence each request through the memory
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    remain_nxt = remain_r;
    second_nxt = second_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = cur_r;
    mem_wdata  = mem_rdata_r;
    mem_re     = 1'b0;
    mem_raddr  = head_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_beat.req_type)
            prq_pkg::REQ_ENQ: begin
              if (count_r > CNT_W'(RING_DEPTH - 2)) begin
                res_nxt.status = prq_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = tail;
                mem_wdata  = in_beat.first_value;
                second_nxt = in_beat.second_value;
                cur_nxt    = ring_next(tail);
                state_nxt  = S_ENQ2;
              end
            end
            prq_pkg::REQ_DEQ: begin
              if (count_r == '0) begin
                res_nxt.status = prq_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = S_DEQ1;
              end
            end
            prq_pkg::REQ_DEL: begin
              if (count_r == '0) begin
                res_nxt.status = prq_pkg::ST_EMPTY;
              end else if (!slot_in_range || slot_off >= count_r) begin
                res_nxt.status = prq_pkg::ST_NOELEM;
              end else if (shift_cnt == '0) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                cur_nxt    = slot_p;
                remain_nxt = shift_cnt;
                mem_re     = 1'b1;
                mem_raddr  = ring_next(slot_p);
                state_nxt  = S_DEL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Write the second word of the pair
      S_ENQ2: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = second_r;
        count_nxt = count_r + CNT_W'(2);
        state_nxt = S_DONE;
      end
      // Take the oldest word, fetch the next one if present
      S_DEQ1: begin
        res_nxt.oldest_word   = mem_rdata_r;
        res_nxt.removed_count = 2'd1;
        head_nxt              = ring_next(head_r);
        count_nxt             = count_r - CNT_W'(1);
        if (count_r > CNT_W'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = ring_next(head_r);
          state_nxt = S_DEQ2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DEQ2: begin
        res_nxt.next_word     = mem_rdata_r;
        res_nxt.removed_count = 2'd2;
        head_nxt              = ring_next(head_r);
        count_nxt             = count_r - CNT_W'(1);
        state_nxt             = S_DONE;
      end
      // Shift one entry toward the head per cycle, read runs one slot ahead
      S_DEL: begin
        mem_we     = 1'b1;
        mem_waddr  = cur_r;
        mem_wdata  = mem_rdata_r;
        cur_nxt    = ring_next(cur_r);
        remain_nxt = remain_r - CNT_W'(1);
        if (remain_r > CNT_W'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = ring_next(ring_next(cur_r));
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load on done, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = res_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    remain_r   <= remain_nxt;
    second_r   <= second_nxt;
    res_r      <= res_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  `PRQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(RING_DEPTH))
  `PRQ_ASSERT_NEXT(a_full_holds, clk, rst_n,
    in_valid && !in_stall && in_beat.req_type == prq_pkg::REQ_ENQ &&
    count_r > CNT_W'(RING_DEPTH - 2), $stable(count_r))
  `PRQ_ASSERT_NOW(a_load_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE))
  `PRQ_ASSERT_NOW(a_words_only_ok, clk, rst_n,
    out_valid_r && out_beat_r.removed_count != 2'd0, out_beat_r.status == prq_pkg::ST_OK)

endmodule

@@ tb/sv/prq_reply_checker.sv @@
`timescale 1ns / 1ps
// Reply checker for the pair ring queue: predicts one reply per accepted request beat
// and compares every accepted result beat with it. Depends on prq_pkg only.
module prq_reply_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  prq_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_stall,
  input  prq_pkg::out_beat_t out_beat,
  output int                 mismatch_count,
  output int                 pending_count
);

  localparam int unsigned DEPTH = 16;

  // Shadow of the queue: words, slot of the oldest word, number of words held
  logic signed [prq_pkg::WORD_W-1:0] word_ring [DEPTH];
  logic [3:0]                        front;
  logic [4:0]                        occupancy;
  prq_pkg::out_beat_t                expected_replies [$];

  // Advance the shadow queue by one request and return the reply it must produce
  function automatic prq_pkg::out_beat_t apply_request(input prq_pkg::in_beat_t req);
    prq_pkg::out_beat_t reply;
    logic [3:0]         tail;
    logic [3:0]         spot;
    logic [3:0]         ahead;
    logic [3:0]         offset;
    int unsigned        k;
    reply = '0;
    reply.status = prq_pkg::ST_OK;
    case (req.req_type)
      prq_pkg::REQ_ENQ: begin
        if (DEPTH - occupancy < 2) begin
          reply.status = prq_pkg::ST_FULL;
        end else begin
          tail = front + occupancy[3:0];
          word_ring[tail] = req.first_value;
          tail = tail + 4'd1;
          word_ring[tail] = req.second_value;
          occupancy = occupancy + 5'd2;
        end
      end
      prq_pkg::REQ_DEQ: begin
        if (occupancy == 0) begin
          reply.status = prq_pkg::ST_EMPTY;
        end else if (occupancy == 1) begin
          reply.removed_count = 2'd1;
          reply.oldest_word = word_ring[front];
          front = front + 4'd1;
          occupancy = '0;
        end else begin
          ahead = front + 4'd1;
          reply.removed_count = 2'd2;
          reply.oldest_word = word_ring[front];
          reply.next_word = word_ring[ahead];
          front = front + 4'd2;
          occupancy = occupancy - 5'd2;
        end
      end
      prq_pkg::REQ_DEL: begin
        // Offset from the head wraps with the ring, so slots behind the head count too
        offset = req.slot_index - front;
        if (occupancy == 0) begin
          reply.status = prq_pkg::ST_EMPTY;
        end else if ({1'b0, offset} >= occupancy) begin
          reply.status = prq_pkg::ST_NOELEM;
        end else begin
          // Close the gap: pull every later word one slot toward the head
          spot = req.slot_index;
          for (k = {28'd0, offset}; k + 1 < occupancy; k++) begin
            ahead = spot + 4'd1;
            word_ring[spot] = word_ring[ahead];
            spot = ahead;
          end
          occupancy = occupancy - 5'd1;
        end
      end
      default: begin
        // Unused request code: no effect, all-zero reply
      end
    endcase
    return reply;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare the result beat first, then queue the prediction for the request beat
  always @(posedge clk) begin
    prq_pkg::out_beat_t want;
    if (!rst_n) begin
      front = '0;
      occupancy = '0;
      expected_replies.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t ns: reply beat with nothing expected, expected none, got %0h",
                   $time, out_beat);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_beat.status));
          check_field("removed_count", 32'(want.removed_count), 32'(out_beat.removed_count));
          check_field("oldest_word", want.oldest_word, out_beat.oldest_word);
          check_field("next_word", want.next_word, out_beat.next_word);
        end
      end
      if (in_valid && !in_stall) begin
        expected_replies.push_back(apply_request(in_beat));
      end
    end
    pending_count = expected_replies.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the pair ring queue testbench: clock, reset, request stimulus, result-side stalls
// and the verdict. Depends on prq_pkg, pair_ring_queue_with_delete and prq_reply_checker.
module testbench;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned ITEM_TARGET  = 1550;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned CALM_FIRST   = 700;
  localparam int unsigned CALM_LAST    = 900;
  localparam int unsigned HOLD_START   = 400;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  prq_pkg::in_beat_t  in_beat;
  logic               out_valid;
  logic               out_stall;
  prq_pkg::out_beat_t out_beat;
  int                 mismatch_count;
  int                 pending_count;
  int unsigned        beats_sent = 0;
  int unsigned        cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pair_ring_queue_with_delete uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  prq_reply_checker reply_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_beat        (in_beat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_beat       (out_beat),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Stretch of beats where neither side idles
  function automatic bit calm_stretch();
    return beats_sent >= CALM_FIRST && beats_sent < CALM_LAST;
  endfunction

  function automatic prq_pkg::in_beat_t make_beat(input logic [1:0] req,
                                                  input logic [31:0] a,
                                                  input logic [31:0] b,
                                                  input logic [3:0] slot);
    prq_pkg::in_beat_t beat;
    beat.req_type = req;
    beat.first_value = a;
    beat.second_value = b;
    beat.slot_index = slot;
    return beat;
  endfunction

  // Request mix per mode: fill-heavy, drain-heavy, balanced
  function automatic prq_pkg::in_beat_t random_beat(input int unsigned mode);
    int unsigned roll;
    int unsigned enq_pct;
    int unsigned deq_pct;
    logic [1:0]  req;
    roll = $urandom_range(99, 0);
    case (mode)
      0:       begin enq_pct = 55; deq_pct = 15; end
      1:       begin enq_pct = 20; deq_pct = 50; end
      default: begin enq_pct = 40; deq_pct = 30; end
    endcase
    if (roll < enq_pct) req = prq_pkg::REQ_ENQ;
    else if (roll < enq_pct + deq_pct) req = prq_pkg::REQ_DEQ;
    else if (roll < 95) req = prq_pkg::REQ_DEL;
    else req = REQ_UNUSED;
    return make_beat(req, $urandom, $urandom, 4'($urandom_range(15, 0)));
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and hold it until taken
  task automatic send_beat(input prq_pkg::in_beat_t beat);
    @(negedge clk);
    while (!calm_stretch() && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  initial begin : stimulus
    prq_pkg::in_beat_t beat;
    int unsigned       real_items;
    int unsigned       mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Empty queue: dequeue and delete both report empty; unused code is a no-op
    send_beat(make_beat(prq_pkg::REQ_DEQ, $urandom, $urandom, 4'd0));
    send_beat(make_beat(prq_pkg::REQ_DEL, $urandom, $urandom, 4'd0));
    send_beat(make_beat(REQ_UNUSED, $urandom, $urandom, 4'd0));
    // Extreme words, then delete of an empty slot and of a middle entry
    send_beat(make_beat(prq_pkg::REQ_ENQ, 32'h7fff_ffff, 32'h8000_0000, 4'd0));
    send_beat(make_beat(prq_pkg::REQ_ENQ, 32'h0000_0000, 32'hffff_ffff, 4'd0));
    send_beat(make_beat(prq_pkg::REQ_DEL, $urandom, $urandom, 4'hf));
    send_beat(make_beat(prq_pkg::REQ_DEL, $urandom, $urandom, 4'd1));
    // Pair dequeue, then single-word dequeue
    send_beat(make_beat(prq_pkg::REQ_DEQ, $urandom, $urandom, 4'd0));
    send_beat(make_beat(prq_pkg::REQ_DEQ, $urandom, $urandom, 4'd0));
    // Fill across the wrap, then enqueue on a full ring and on one free slot
    for (int i = 0; i < 8; i++) begin
      send_beat(make_beat(prq_pkg::REQ_ENQ, $urandom, $urandom, 4'd0));
    end
    send_beat(make_beat(prq_pkg::REQ_ENQ, $urandom, $urandom, 4'd0));
    send_beat(make_beat(prq_pkg::REQ_DEL, $urandom, $urandom, 4'd2));
    send_beat(make_beat(prq_pkg::REQ_ENQ, $urandom, $urandom, 4'd0));
    // Delete at the head, then a slot behind the head that is now free
    send_beat(make_beat(prq_pkg::REQ_DEL, $urandom, $urandom, 4'd3));
    send_beat(make_beat(prq_pkg::REQ_DEL, $urandom, $urandom, 4'd2));
    send_beat(make_beat(prq_pkg::REQ_DEQ, $urandom, $urandom, 4'd0));
    send_beat(make_beat(REQ_UNUSED, $urandom, $urandom, 4'($urandom_range(15, 0))));

    // Random traffic in blocks of changing mix so the ring swings between full and empty
    real_items = 0;
    mode = 2;
    while (real_items < ITEM_TARGET) begin
      if (real_items % 64 == 0) mode = $urandom_range(2, 0);
      beat = random_beat(mode);
      send_beat(beat);
      real_items++;
    end

    // Drop valid, drain outstanding replies, then idle for the drain period
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("pair_ring_queue_with_delete test passed");
    end else begin
      $display("pair_ring_queue_with_delete test failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off so the block backs up its input
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && beats_sent >= HOLD_START) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
      end else begin
        out_stall <= !calm_stretch() && $urandom_range(99, 0) < IDLE_PCT;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pair_ring_queue_with_delete test failed");
      $finish;
    end
  end

endmodule
